[hdl/ntfsfr_pkg.sv]
// ----------------------------------------------------------------------------
// ntfsfr_pkg
// Shared types and codes for the mapping-pairs first-run decoder.
// ----------------------------------------------------------------------------
package ntfsfr_pkg;

    localparam int LcnW   = 64;
    localparam int LimitW = 16;
    localparam int CountW = 4;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_OVERRUN    = 3'd1,
        ST_NO_LENGTH  = 3'd2,
        ST_LEN_BOUND  = 3'd3,
        ST_NEG_LENGTH = 3'd4,
        ST_HOLE       = 3'd5,
        ST_OFF_BOUND  = 3'd6,
        ST_LCN_LOW    = 3'd7
    } status_t;

    // Decoder phase
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_LEN  = 2'd1,
        PH_OFF  = 2'd2
    } phase_t;

    // One input transfer
    typedef struct packed {
        logic [7:0]        data_byte;
        logic              start_req;
        logic [LimitW-1:0] limit;
        logic              attr_overrun;
    } item_t;

    // One result
    typedef struct packed {
        logic              valid;
        logic [LcnW-1:0]   lcn;
        status_t           status;
    } result_t;

endpackage

[hdl/ntfs_first_run_decoder.sv]
// ----------------------------------------------------------------------------
// ntfs_first_run_decoder
// Decodes the first run of a mapping-pairs array, one byte per transfer,
// and returns the first cluster number or an error status per run list.
// ----------------------------------------------------------------------------
//  channel | direction | ports                                   | handshake
//  input   | in        | s_data_byte s_start_req s_limit          | s_valid/s_ready
//          |           | s_attr_overrun                          |
//  result  | out       | m_lcn m_status                          | m_valid/m_ready
//
//  One byte per cycle while m_ready does not stall; after its last byte is
//  transferred in, a result passes the input register, then decode into the result register.
//  The decode step advances whenever the result register is empty or drained
//  in the same cycle, so a stalled m_ready backs up into s_ready.
//  Synchronous active-low reset empties both registers and returns to idle.
// ----------------------------------------------------------------------------
module ntfs_first_run_decoder (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [7:0]                              s_data_byte,
    input  logic                                    s_start_req,
    input  logic [ntfsfr_pkg::LimitW-1:0]           s_limit,
    input  logic                                    s_attr_overrun,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [ntfsfr_pkg::LcnW-1:0]      m_lcn,
    output logic [2:0]                              m_status
);
    import ntfsfr_pkg::*;

    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    fire;
    result_t res;

    assign s_item.data_byte    = s_data_byte;
    assign s_item.start_req    = s_start_req;
    assign s_item.limit        = s_limit;
    assign s_item.attr_overrun = s_attr_overrun;

    // Decode advances when the result slot can take a possible result
    assign fire = item_valid && (!m_valid || m_ready);

    ntfsfr_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .pop        (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    ntfsfr_decode u_dec (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (item),
        .res     (res)
    );

    ntfsfr_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .res      (res),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_lcn    (m_lcn),
        .m_status (m_status)
    );

endmodule

[hdl/ntfsfr_in_stage.sv]
// ----------------------------------------------------------------------------
// ntfsfr_in_stage
// Input register: holds one accepted transfer until the decode step takes it.
// ----------------------------------------------------------------------------
module ntfsfr_in_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ntfsfr_pkg::item_t   s_item,
    input  logic                pop,
    output logic                item_valid,
    output ntfsfr_pkg::item_t   item
);
    import ntfsfr_pkg::*;

    logic  valid_reg, valid_next;
    item_t item_reg, item_next;

    // Free when empty or when the held item leaves this cycle
    assign s_ready = !valid_reg || pop;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
            item_next  = s_item;
        end else if (pop) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[hdl/ntfsfr_decode.sv]
// ----------------------------------------------------------------------------
// ntfsfr_decode
// Run-list state and the per-byte decode: header checks, field assembly,
// bound checks and the first cluster number.
// ----------------------------------------------------------------------------
module ntfsfr_decode (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  ntfsfr_pkg::item_t   item,
    output ntfsfr_pkg::result_t res
);
    import ntfsfr_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [CountW-1:0] len_cnt_reg, len_cnt_next;
    logic [CountW-1:0] off_cnt_reg, off_cnt_next;
    logic [CountW-1:0] idx_reg, idx_next;
    logic [LcnW-1:0]   acc_reg, acc_next;
    logic [LimitW-1:0] limit_reg, limit_next;

    logic [CountW-1:0] field_cnt;
    logic              last;
    logic [LcnW-1:0]   ext;
    logic [LcnW-1:0]   acc_sum;
    logic [CountW:0]   pair_len;

    // Field byte placement; the top byte sign-extends
    always_comb begin
        field_cnt = (phase_reg == PH_LEN) ? len_cnt_reg : off_cnt_reg;
        last      = ({1'b0, idx_reg} + (CountW+1)'(1)) == {1'b0, field_cnt};
        ext       = {{(LcnW-8){last & item.data_byte[7]}}, item.data_byte};
        // positions 8 and up fall out of the 64-bit value
        acc_sum   = idx_reg[CountW-1] ? acc_reg
                                      : (acc_reg | (ext << {idx_reg[2:0], 3'b000}));
        pair_len  = {1'b0, len_cnt_reg} + {1'b0, off_cnt_reg};
    end

    // Next state and result
    always_comb begin
        phase_next   = phase_reg;
        len_cnt_next = len_cnt_reg;
        off_cnt_next = off_cnt_reg;
        idx_next     = idx_reg;
        acc_next     = acc_reg;
        limit_next   = limit_reg;
        res.valid    = 1'b0;
        res.lcn      = '0;
        res.status   = ST_OK;
        if (fire) begin
            if (item.start_req) begin
                // header byte: restart, checks on counts
                limit_next   = item.limit;
                len_cnt_next = item.data_byte[3:0];
                off_cnt_next = item.data_byte[7:4];
                idx_next     = '0;
                acc_next     = '0;
                phase_next   = PH_IDLE;
                if (item.attr_overrun) begin
                    res.valid  = 1'b1;
                    res.status = ST_OVERRUN;
                end else if (item.data_byte[3:0] == '0) begin
                    res.valid  = 1'b1;
                    res.status = ST_NO_LENGTH;
                end else if (LimitW'(item.data_byte[3:0]) > item.limit) begin
                    res.valid  = 1'b1;
                    res.status = ST_LEN_BOUND;
                end else begin
                    phase_next = PH_LEN;
                end
            end else if (phase_reg != PH_IDLE) begin
                acc_next = acc_sum;
                idx_next = idx_reg + CountW'(1);
                if (last) begin
                    if (phase_reg == PH_LEN) begin
                        if (acc_sum[LcnW-1]) begin
                            res.valid  = 1'b1;
                            res.status = ST_NEG_LENGTH;
                            phase_next = PH_IDLE;
                        end else if (off_cnt_reg == '0) begin
                            res.valid  = 1'b1;
                            res.status = ST_HOLE;
                            phase_next = PH_IDLE;
                        end else if (LimitW'(pair_len) > limit_reg) begin
                            res.valid  = 1'b1;
                            res.status = ST_OFF_BOUND;
                            phase_next = PH_IDLE;
                        end else begin
                            phase_next = PH_OFF;
                            idx_next   = '0;
                            acc_next   = '0;
                        end
                    end else begin
                        res.valid  = 1'b1;
                        phase_next = PH_IDLE;
                        if (acc_sum[LcnW-1] && (acc_sum != '1)) begin
                            res.status = ST_LCN_LOW;
                        end else begin
                            res.lcn = acc_sum;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            len_cnt_reg <= '0;
            off_cnt_reg <= '0;
            idx_reg     <= '0;
            acc_reg     <= '0;
            limit_reg   <= '0;
        end else begin
            phase_reg   <= phase_next;
            len_cnt_reg <= len_cnt_next;
            off_cnt_reg <= off_cnt_next;
            idx_reg     <= idx_next;
            acc_reg     <= acc_next;
            limit_reg   <= limit_next;
        end
    end

endmodule

[hdl/ntfsfr_out_stage.sv]
// ----------------------------------------------------------------------------
// ntfsfr_out_stage
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module ntfsfr_out_stage (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  ntfsfr_pkg::result_t       res,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [ntfsfr_pkg::LcnW-1:0] m_lcn,
    output logic [2:0]                m_status
);
    import ntfsfr_pkg::*;

    logic            valid_reg, valid_next;
    logic [LcnW-1:0] lcn_reg, lcn_next;
    status_t         status_reg, status_next;

    // Load a new result; otherwise drop the held one once taken
    always_comb begin
        valid_next  = valid_reg;
        lcn_next    = lcn_reg;
        status_next = status_reg;
        if (res.valid) begin
            valid_next  = 1'b1;
            lcn_next    = res.lcn;
            status_next = res.status;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        lcn_reg    <= lcn_next;
        status_reg <= status_next;
    end

    assign m_valid  = valid_reg;
    assign m_lcn    = lcn_reg;
    assign m_status = status_reg;

endmodule

[hdl/ntfsfr_checker.sv]
// ----------------------------------------------------------------------------
// ntfsfr_checker
// Port-level checks for the first-run decoder, bound to the top level.
// ----------------------------------------------------------------------------
module ntfsfr_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic signed [ntfsfr_pkg::LcnW-1:0] m_lcn,
    input logic [2:0]                         m_status
);
    import ntfsfr_pkg::*;

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_lcn) && $stable(m_status))
        else $error("result changed while stalled");

    // Any error reports a zero cluster number
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_OK) |-> (m_lcn == '0))
        else $error("nonzero lcn with error status");

    // A good result is never below -1
    a_ok_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_OK) |-> (!m_lcn[LcnW-1] || (m_lcn == '1)))
        else $error("ok result below -1");

    // Reset empties the result register
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind ntfs_first_run_decoder ntfsfr_checker u_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_lcn    (m_lcn),
    .m_status (m_status)
);

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the mapping-pairs first-run decoder. A directed
// table covers every status code and the corner cases of the header and
// field decode; random run lists (well formed, cut short, and noise) follow.
// Every byte transfer runs through a local run-list decoder model, and each
// result transfer is checked against the oldest expected first run.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ntfsfr_pkg::*;

    localparam int DirN        = 24;
    localparam int RandomItems = 1200;
    localparam int StallLimit  = 500;
    localparam int DrainCycles = 8;
    localparam int MaxPrinted  = 50;

    // How the expected result of one table row is obtained
    typedef enum logic [1:0] {
        ROW_PREDICT   = 2'd0,
        ROW_NO_RESULT = 2'd1,
        ROW_RESULT    = 2'd2
    } row_kind_t;

    typedef struct packed {
        logic [7:0]        data;
        logic              start;
        logic [LimitW-1:0] lim;
        logic              ovr;
        row_kind_t         kind;
        logic [LcnW-1:0]   lcn;
        status_t           st;
    } stim_row_t;

    typedef struct packed {
        logic [LcnW-1:0] lcn;
        status_t         status;
    } run_result_t;

    logic                     aclk;
    logic                     aresetn        = 1'b0;
    logic                     s_valid        = 1'b0;
    logic                     s_ready;
    logic [7:0]               s_data_byte    = '0;
    logic                     s_start_req    = 1'b0;
    logic [LimitW-1:0]        s_limit        = '0;
    logic                     s_attr_overrun = 1'b0;
    logic                     m_valid;
    logic                     m_ready        = 1'b1;
    logic signed [LcnW-1:0]   m_lcn;
    logic [2:0]               m_status;

    // Expectation attached to the byte currently on the input channel
    row_kind_t                drv_kind = ROW_PREDICT;
    logic [LcnW-1:0]          drv_lcn  = '0;
    status_t                  drv_st   = ST_OK;

    // Run-list decoder model state
    phase_t                   dec_phase = PH_IDLE;
    logic [CountW-1:0]        len_cnt   = '0;
    logic [CountW-1:0]        off_cnt   = '0;
    logic [4:0]               byte_idx  = '0;
    logic [LcnW-1:0]          acc       = '0;
    logic [LimitW-1:0]        lim_saved = '0;

    run_result_t              first_run_q[$];
    int                       mismatches   = 0;
    int                       useful_items = 0;
    int                       quiet_cycles = 0;
    bit                       gaps_on      = 1'b1;

    // Directed rows: typed results where the outcome is obvious
    stim_row_t directed_rows [DirN] = '{
        '{8'hAB, 1'b0, 16'd100,   1'b0, ROW_NO_RESULT, 64'd0, ST_OK},        // idle byte
        '{8'h11, 1'b1, 16'd100,   1'b1, ROW_RESULT,    64'd0, ST_OVERRUN},
        '{8'hF0, 1'b1, 16'hFFFF,  1'b0, ROW_RESULT,    64'd0, ST_NO_LENGTH},
        '{8'h02, 1'b1, 16'd1,     1'b0, ROW_RESULT,    64'd0, ST_LEN_BOUND},
        '{8'h11, 1'b1, 16'd0,     1'b0, ROW_RESULT,    64'd0, ST_LEN_BOUND},
        '{8'h11, 1'b1, 16'd2,     1'b0, ROW_PREDICT,   64'd0, ST_OK},
        '{8'h80, 1'b0, 16'd0,     1'b0, ROW_RESULT,    64'd0, ST_NEG_LENGTH},
        '{8'h01, 1'b1, 16'd10,    1'b0, ROW_PREDICT,   64'd0, ST_OK},
        '{8'h05, 1'b0, 16'd0,     1'b0, ROW_RESULT,    64'd0, ST_HOLE},
        '{8'h21, 1'b1, 16'd2,     1'b0, ROW_PREDICT,   64'd0, ST_OK},
        '{8'h01, 1'b0, 16'd0,     1'b0, ROW_RESULT,    64'd0, ST_OFF_BOUND},
        '{8'h11, 1'b1, 16'd2,     1'b0, ROW_PREDICT,   64'd0, ST_OK},        // exact fit
        '{8'h01, 1'b0, 16'd0,     1'b0, ROW_PREDICT,   64'd0, ST_OK},
        '{8'hFE, 1'b0, 16'd0,     1'b0, ROW_RESULT,    64'd0, ST_LCN_LOW},
        '{8'h11, 1'b1, 16'hFFFF,  1'b0, ROW_PREDICT,   64'd0, ST_OK},
        '{8'h7F, 1'b0, 16'hFFFF,  1'b1, ROW_PREDICT,   64'd0, ST_OK},
        '{8'hFF, 1'b0, 16'd0,     1'b0, ROW_RESULT,    '1,    ST_OK},        // lcn -1
        '{8'h55, 1'b0, 16'd0,     1'b0, ROW_NO_RESULT, 64'd0, ST_OK},        // after result
        '{8'h22, 1'b1, 16'd10,    1'b0, ROW_PREDICT,   64'd0, ST_OK},
        '{8'h01, 1'b0, 16'd0,     1'b0, ROW_PREDICT,   64'd0, ST_OK},
        '{8'h11, 1'b1, 16'd5,     1'b0, ROW_PREDICT,   64'd0, ST_OK},        // restart
        '{8'h03, 1'b0, 16'd0,     1'b0, ROW_PREDICT,   64'd0, ST_OK},
        '{8'h7F, 1'b0, 16'd0,     1'b0, ROW_PREDICT,   64'd0, ST_OK},
        '{8'hFF, 1'b1, 16'hFFFF,  1'b0, ROW_PREDICT,   64'd0, ST_OK}         // left open
    };

    ntfs_first_run_decoder uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_start_req    (s_start_req),
        .s_limit        (s_limit),
        .s_attr_overrun (s_attr_overrun),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_lcn          (m_lcn),
        .m_status       (m_status)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MaxPrinted) begin
            $display("%0t mismatch: %s", $time, msg);
        end
    endtask

    // Decode one byte of a run list; run_done marks a first-run result
    task automatic decode_run_byte(input logic [7:0] b, input logic is_header,
                                   input logic [LimitW-1:0] lim, input logic ovr,
                                   output bit run_done, output run_result_t res);
        logic            last;
        logic [LcnW-1:0] addend;
        run_done = 1'b0;
        res      = '0;
        if (is_header) begin
            lim_saved = lim;
            len_cnt   = b[3:0];
            off_cnt   = b[7:4];
            byte_idx  = '0;
            acc       = '0;
            dec_phase = PH_IDLE;
            run_done  = 1'b1;
            if (ovr) begin
                res.status = ST_OVERRUN;
            end else if (len_cnt == '0) begin
                res.status = ST_NO_LENGTH;
            end else if (16'(len_cnt) > lim_saved) begin
                res.status = ST_LEN_BOUND;
            end else begin
                run_done  = 1'b0;
                dec_phase = PH_LEN;
            end
        end else if (dec_phase != PH_IDLE) begin
            last = (dec_phase == PH_LEN) ? (int'(byte_idx) + 1 == int'(len_cnt))
                                         : (int'(byte_idx) + 1 == int'(off_cnt));
            // little endian, sign taken from the field's top byte
            addend = {56'd0, b};
            if (last && b[7]) begin
                addend[63:8] = '1;
            end
            if (byte_idx < 5'd8) begin
                acc = acc + (addend << (8 * byte_idx));
            end
            byte_idx = byte_idx + 5'd1;
            if (last && dec_phase == PH_LEN) begin
                run_done = 1'b1;
                if (acc[63]) begin
                    res.status = ST_NEG_LENGTH;
                end else if (off_cnt == '0) begin
                    res.status = ST_HOLE;
                end else if (int'(len_cnt) + int'(off_cnt) > int'(lim_saved)) begin
                    res.status = ST_OFF_BOUND;
                end else begin
                    run_done  = 1'b0;
                    dec_phase = PH_OFF;
                    byte_idx  = '0;
                    acc       = '0;
                end
            end else if (last) begin
                run_done = 1'b1;
                if (acc[63] && acc != '1) begin
                    res.status = ST_LCN_LOW;
                end else begin
                    res.lcn = acc;
                end
            end
            if (run_done) begin
                dec_phase = PH_IDLE;
            end
        end
    endtask

    // Put one byte on the input channel and hold it until the transfer
    task automatic send_row(input stim_row_t r);
        if (gaps_on && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_data_byte    <= r.data;
        s_start_req    <= r.start;
        s_limit        <= r.lim;
        s_attr_overrun <= r.ovr;
        drv_kind       <= r.kind;
        drv_lcn        <= r.lcn;
        drv_st         <= r.st;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Field byte count: mostly short, sometimes past eight bytes
    function automatic int field_bytes(input int zero_pct);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < zero_pct) return 0;
        if (pick < 70) return $urandom_range(1, 3);
        if (pick < 90) return $urandom_range(4, 8);
        return $urandom_range(9, 15);
    endfunction

    // One random run list: well formed, cut short, or plain noise
    task automatic send_random_list();
        int        mode;
        int        lc;
        int        oc;
        int        nbytes;
        int        omode;
        stim_row_t r;
        r      = '0;
        r.kind = ROW_PREDICT;
        r.st   = ST_OK;
        mode   = $urandom_range(0, 99);
        if (mode >= 88) begin
            repeat ($urandom_range(1, 4)) begin
                r.data  = 8'($urandom);
                r.start = ($urandom_range(0, 3) == 0);
                r.lim   = 16'($urandom);
                r.ovr   = 1'($urandom);
                send_row(r);
            end
            return;
        end
        lc      = field_bytes(3);
        oc      = field_bytes(8);
        r.data  = {oc[3:0], lc[3:0]};
        r.start = 1'b1;
        r.ovr   = ($urandom_range(0, 19) == 0);
        case ($urandom_range(0, 9))
            0: begin
                r.lim = 16'($urandom);
            end
            1: begin
                r.lim = (lc + oc > 0) ? 16'(lc + oc - 1) : '0;
            end
            2: begin
                r.lim = 16'(lc + oc);
            end
            default: begin
                r.lim = 16'($urandom_range(lc + oc, 65535));
            end
        endcase
        send_row(r);
        // a cut list is abandoned by the next header
        nbytes  = (mode >= 75) ? $urandom_range(0, lc + oc) : lc + oc;
        omode   = $urandom_range(0, 3);
        r.start = 1'b0;
        for (int i = 0; i < nbytes; i++) begin
            r.data = 8'($urandom);
            r.lim  = 16'($urandom);
            r.ovr  = 1'($urandom);
            if (i == lc - 1 && $urandom_range(0, 6) != 0) begin
                r.data[7] = 1'b0;
            end else if (i >= lc) begin
                // offset shapes: all ones, negative top byte, or positive top
                if (omode == 1 || (omode == 2 && i == lc + oc - 1)) begin
                    r.data = 8'hFF;
                end else if (omode == 3 && i == lc + oc - 1) begin
                    r.data[7] = 1'b0;
                end
            end
            send_row(r);
        end
        // stray bytes once the list is done
        if ($urandom_range(0, 3) == 0) begin
            r.data = 8'($urandom);
            send_row(r);
        end
    endtask

    // Receiver: random stall bursts while gaps are enabled
    initial begin : result_sink
        int hold;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (hold > 0) begin
                hold--;
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                hold = $urandom_range(1, 6) - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Check result transfers, model byte transfers, watch for a hang
    always @(posedge aclk) begin : result_check
        run_result_t exp_run;
        bit          run_done;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (first_run_q.size() == 0) begin
                    report_mismatch($sformatf("result lcn %h status %0d with nothing pending",
                                              m_lcn, m_status));
                end else begin
                    exp_run = first_run_q.pop_front();
                    if (m_lcn !== exp_run.lcn) begin
                        report_mismatch($sformatf("lcn %h, expected %h", m_lcn, exp_run.lcn));
                    end
                    if (m_status !== exp_run.status) begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  m_status, exp_run.status));
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_start_req || dec_phase != PH_IDLE) begin
                    useful_items++;
                end
                decode_run_byte(s_data_byte, s_start_req, s_limit, s_attr_overrun,
                                run_done, exp_run);
                case (drv_kind)
                    ROW_PREDICT: begin
                        if (run_done) begin
                            first_run_q.push_back(exp_run);
                        end
                    end
                    ROW_RESULT: begin
                        exp_run.lcn    = drv_lcn;
                        exp_run.status = drv_st;
                        first_run_q.push_back(exp_run);
                    end
                    default: begin
                    end
                endcase
            end
        end
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= StallLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Main sequence: reset, directed table, random lists, drain
    initial begin : stimulus
        bit paused;
        paused = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (directed_rows[i]) begin
            send_row(directed_rows[i]);
        end
        while (useful_items < DirN + RandomItems) begin
            if (useful_items >= DirN + RandomItems - 150) begin
                gaps_on = 1'b0;
            end else if ($urandom_range(0, 29) == 0) begin
                gaps_on = !gaps_on;
            end
            // hold off the sender until every pending result is out
            if (!paused && useful_items >= DirN + RandomItems / 2) begin
                paused = 1'b1;
                s_valid <= 1'b0;
                do @(posedge aclk); while (first_run_q.size() != 0);
            end
            send_random_list();
        end
        s_valid <= 1'b0;
        do @(posedge aclk); while (first_run_q.size() != 0);
        repeat (DrainCycles) @(posedge aclk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
